/* hdl/ppht_pkg.sv */
// Package for the point pick hit test block: word types, codes, constants
// and saturation helpers. No dependencies.
package ppht_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW        = 32;   // coordinate width
  localparam int MW        = 34;   // multiplier operand width
  localparam int PW        = 2*MW; // multiplier product width
  localparam int IDW       = 64;

  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_HEADER = 2'd1;
  localparam logic [1:0] FUNC_VERTEX = 2'd2;
  localparam logic [1:0] FUNC_FINISH = 2'd3;

  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_DISC   = 3'd1;
  localparam logic [2:0] KIND_CIRCLE = 3'd2;
  localparam logic [2:0] KIND_LINE   = 3'd3;
  localparam logic [2:0] KIND_OPEN   = 3'd4;
  localparam logic [2:0] KIND_CLOSED = 3'd5;

  typedef struct packed {
    logic [1:0]             func;
    logic signed [CW-1:0]   pos_x;
    logic signed [CW-1:0]   pos_y;
    logic signed [CW-1:0]   axis1_x;
    logic signed [CW-1:0]   axis1_y;
    logic signed [CW-1:0]   axis2_x;
    logic signed [CW-1:0]   axis2_y;
    logic [2:0]             kind;
    logic [30:0]            radius;
    logic [30:0]            width;
    logic [IDW-1:0]         node_id;
    logic                   last;
  } in_word_t;

  typedef struct packed {
    logic           hit;
    logic [IDW-1:0] hit_id;
  } out_word_t;

  // sign-extend a coordinate to product width
  function automatic logic signed [PW-1:0] ext_p(input logic signed [CW-1:0] a);
    ext_p = PW'(a);
  endfunction

  // sign-extend a coordinate to multiplier operand width
  function automatic logic signed [MW-1:0] ext_m(input logic signed [CW-1:0] a);
    ext_m = MW'(a);
  endfunction

  // saturate a wide signed value to the signed 32-bit range
  function automatic logic signed [CW-1:0] sat32(input logic signed [PW-1:0] v);
    logic fits;
    fits = (&v[PW-1:CW-1]) | ~(|v[PW-1:CW-1]);
    if (fits) sat32 = v[CW-1:0];
    else if (v[PW-1]) sat32 = {1'b1, {(CW-1){1'b0}}};
    else sat32 = {1'b0, {(CW-1){1'b1}}};
  endfunction

  // saturate a non-negative wide value to 31 bits
  function automatic logic [30:0] sat_u31(input logic signed [PW-1:0] v);
    if (|v[PW-1:31]) sat_u31 = {31{1'b1}};
    else sat_u31 = v[30:0];
  endfunction

endpackage

/* hdl/ppht_mul.sv */
// Shared signed multiplier with registered product.
// Depends on ppht_pkg.
module ppht_mul (
  input  logic                           clk,
  input  logic signed [ppht_pkg::MW-1:0] a,
  input  logic signed [ppht_pkg::MW-1:0] b,
  output logic signed [ppht_pkg::PW-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

/* hdl/ppht_sqrt.sv */
// Iterative floor square root of a 64-bit value, one result bit per cycle.
// Standalone; does not use ppht_pkg.
module ppht_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] val,
  output logic        done_r,
  output logic [31:0] root_r
);

  logic [63:0] val_r;
  logic [33:0] rem_r;
  logic [4:0]  cnt_r;
  logic        run_r;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic [33:0] rem_nxt;
  logic [31:0] root_nxt;

  always_comb begin
    rem_sh = {rem_r, val_r[63:62]};
    trial  = {2'b00, root_r, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = 34'(rem_sh - trial);
      root_nxt = {root_r[30:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh[33:0];
      root_nxt = {root_r[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        val_r  <= val;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
        run_r  <= 1'b1;
      end else if (run_r) begin
        val_r  <= {val_r[61:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/ppht_div.sv */
// Restoring fraction divider: FRAC_BITS quotient bits of num/den, num < den.
// Depends on ppht_pkg.
module ppht_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [63:0]                      num,
  input  logic [63:0]                      den,
  output logic                             done_r,
  output logic [ppht_pkg::FRAC_BITS-1:0]   quo_r
);

  localparam int CNTW = $clog2(ppht_pkg::FRAC_BITS);

  logic [64:0]     rem_r;
  logic [63:0]     den_r;
  logic [CNTW-1:0] cnt_r;
  logic            run_r;
  logic [64:0]     rem_sh;

  assign rem_sh = {rem_r[63:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= {1'b0, num};
        den_r <= den;
        quo_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_r <= rem_sh - {1'b0, den_r};
          quo_r <= {quo_r[ppht_pkg::FRAC_BITS-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[ppht_pkg::FRAC_BITS-2:0], 1'b0};
        end
        cnt_r <= cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(ppht_pkg::FRAC_BITS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/point_pick_hit_test.sv */
// Point pick hit test: finds the front-most shape under a query point.
// Uses ppht_pkg, ppht_mul, ppht_sqrt and ppht_div.
//
// Usage: send a start word (query point), then per node back to front a
// header word (transform, kind, radius, width, id) followed for lines and
// polylines by vertex words, then a finish word. Finish yields one result
// word: hit flag and id of the front-most hit node (0 if none).
// Input channel: in_valid / in_stall / in_word. in_stall is high while a
// word is being worked on; one word at a time.
// Output channel: out_valid / out_stall / out_word, held in a register
// until taken; no new input word is taken while it waits.
// Work per word: start and finish need no further steps, and the result
// then waits until taken; a header runs two square root waits plus
// multiplier steps, and a distance test for a disc or ring; a vertex is
// dropped when stray, else mapped to world, and each segment tested takes
// nine multiplies plus a divide wait when the foot lies inside it, with up
// to two segments for the last vertex of a closed polyline. All products
// run through one shared registered multiplier, stepped by the sequencer below.
// Reset (synchronous, rst_n low) clears the query, found flag and id,
// node kind and vertex count; the output goes invalid.
module point_pick_hit_test (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ppht_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output ppht_pkg::out_word_t out_word
);

  localparam int CW = ppht_pkg::CW;
  localparam int MW = ppht_pkg::MW;
  localparam int PW = ppht_pkg::PW;
  localparam int FB = ppht_pkg::FRAC_BITS;

  typedef enum logic [5:0] {
    S_IDLE, S_OUT,
    H_A1X, H_A1Y, H_S1, H_W1, H_A2X, H_A2Y, H_S2, H_W2,
    H_R, H_W, H_D, H_DY, H_B, H_C, H_L,
    V_X1, V_X2, V_Y1, V_Y2, V_V, V_LAST,
    G_DX, G_DY, G_LIM, G_T1, G_T2, G_DOT, G_DIV, G_CX, G_CY, G_CYW,
    G_E1, G_E2, G_E3
  } state_t;

  state_t state_r;

  // node and query state
  logic signed [CW-1:0] qx_r, qy_r;
  logic signed [CW-1:0] xf_r [6];   // tx, ty, a1x, a1y, a2x, a2y
  logic [2:0]           kind_r;
  logic [30:0]          rad_r, wid_r, srad_r, swid_r, scale_r;
  logic [63:0]          nid_r;
  logic signed [CW-1:0] vx_r, vy_r;
  logic                 last_r;
  logic signed [CW-1:0] fvx_r, fvy_r, pvx_r, pvy_r;
  logic [1:0]           vseen_r;
  logic                 found_r;
  logic [63:0]          fid_r;

  // work registers
  logic signed [PW-1:0] acc_r;
  logic [31:0]          l1_r;
  logic [64:0]          d2_r, len2_r, lim_r;
  logic signed [CW-1:0] nwx_r;
  logic signed [CW-1:0] sx_r, sy_r, ex_r, ey_r, dx_r, dy_r, cx_r, cy_r;
  logic                 close_r;
  logic                 out_valid_r;
  ppht_pkg::out_word_t  out_r;

  // shared units
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_r;
  logic                 sq_start, sq_done;
  logic [31:0]          sq_root;
  logic                 dv_start, dv_done;
  logic [FB-1:0]        alpha;

  // derived values
  logic signed [PW-1:0] psh, acc_sum, acc_sh_sum, dot;
  logic signed [CW-1:0] hdx, hdy, gdx, gdy, gwx, gwy, gex, gey, nwy;
  logic [31:0]          hi, mx;
  logic [30:0]          lo;
  logic [63:0]          dotc;
  logic                 dot_le0;
  logic [64:0]          e_d2;
  logic signed [MW-1:0] alpha_m;

  ppht_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_r(prod_r));

  ppht_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .val(acc_sum[63:0]),
    .done_r(sq_done), .root_r(sq_root)
  );

  ppht_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dotc), .den(len2_r[63:0]),
    .done_r(dv_done), .quo_r(alpha)
  );

  always_comb begin
    psh        = prod_r >>> FB;
    acc_sum    = acc_r + prod_r;
    acc_sh_sum = acc_r + psh;
    hdx = ppht_pkg::sat32(ppht_pkg::ext_p(qx_r) - ppht_pkg::ext_p(xf_r[0]));
    hdy = ppht_pkg::sat32(ppht_pkg::ext_p(qy_r) - ppht_pkg::ext_p(xf_r[1]));
    gdx = ppht_pkg::sat32(ppht_pkg::ext_p(ex_r) - ppht_pkg::ext_p(sx_r));
    gdy = ppht_pkg::sat32(ppht_pkg::ext_p(ey_r) - ppht_pkg::ext_p(sy_r));
    gwx = ppht_pkg::sat32(ppht_pkg::ext_p(qx_r) - ppht_pkg::ext_p(sx_r));
    gwy = ppht_pkg::sat32(ppht_pkg::ext_p(qy_r) - ppht_pkg::ext_p(sy_r));
    gex = ppht_pkg::sat32(ppht_pkg::ext_p(qx_r) - ppht_pkg::ext_p(cx_r));
    gey = ppht_pkg::sat32(ppht_pkg::ext_p(qy_r) - ppht_pkg::ext_p(cy_r));
    nwy = ppht_pkg::sat32(acc_sh_sum);
    hi  = {1'b0, srad_r} + {1'b0, swid_r};
    lo  = srad_r - swid_r;
    mx  = (l1_r > sq_root) ? l1_r : sq_root;
    dot = acc_sum;
    dot_le0 = dot[PW-1] | (dot == '0);
    // positive dot saturates to the signed 64-bit maximum
    dotc = dot[63] ? {1'b0, {63{1'b1}}} : dot[63:0];
    e_d2 = acc_sum[64:0];
    alpha_m = $signed({{(MW-FB){1'b0}}, alpha});
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      H_A1X: begin mul_a = ppht_pkg::ext_m(xf_r[2]); mul_b = mul_a; end
      H_A1Y: begin mul_a = ppht_pkg::ext_m(xf_r[3]); mul_b = mul_a; end
      H_A2X: begin mul_a = ppht_pkg::ext_m(xf_r[4]); mul_b = mul_a; end
      H_A2Y: begin mul_a = ppht_pkg::ext_m(xf_r[5]); mul_b = mul_a; end
      H_R: begin
        mul_a = $signed(MW'(rad_r));
        mul_b = $signed(MW'(scale_r));
      end
      H_W: begin
        mul_a = $signed(MW'(wid_r));
        mul_b = $signed(MW'(scale_r));
      end
      H_D:  begin mul_a = ppht_pkg::ext_m(hdx); mul_b = mul_a; end
      H_DY: begin mul_a = ppht_pkg::ext_m(hdy); mul_b = mul_a; end
      H_B: begin
        if (kind_r == ppht_pkg::KIND_DISC) mul_a = $signed(MW'(srad_r));
        else mul_a = $signed(MW'(hi));
        mul_b = mul_a;
      end
      H_C:  begin mul_a = $signed(MW'(lo)); mul_b = mul_a; end
      V_X1: begin mul_a = ppht_pkg::ext_m(xf_r[2]); mul_b = ppht_pkg::ext_m(vx_r); end
      V_X2: begin mul_a = ppht_pkg::ext_m(xf_r[4]); mul_b = ppht_pkg::ext_m(vy_r); end
      V_Y1: begin mul_a = ppht_pkg::ext_m(xf_r[3]); mul_b = ppht_pkg::ext_m(vx_r); end
      V_Y2: begin mul_a = ppht_pkg::ext_m(xf_r[5]); mul_b = ppht_pkg::ext_m(vy_r); end
      G_DX:  begin mul_a = ppht_pkg::ext_m(gdx); mul_b = mul_a; end
      G_DY:  begin mul_a = ppht_pkg::ext_m(dy_r); mul_b = mul_a; end
      G_LIM: begin mul_a = $signed(MW'(swid_r)); mul_b = mul_a; end
      G_T1:  begin mul_a = ppht_pkg::ext_m(gwx); mul_b = ppht_pkg::ext_m(dx_r); end
      G_T2:  begin mul_a = ppht_pkg::ext_m(gwy); mul_b = ppht_pkg::ext_m(dy_r); end
      G_CX:  begin mul_a = alpha_m; mul_b = ppht_pkg::ext_m(dx_r); end
      G_CY:  begin mul_a = alpha_m; mul_b = ppht_pkg::ext_m(dy_r); end
      G_E1:  begin mul_a = ppht_pkg::ext_m(gex); mul_b = mul_a; end
      G_E2:  begin mul_a = ppht_pkg::ext_m(gey); mul_b = mul_a; end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sq_start = (state_r == H_S1) || (state_r == H_S2);
  assign dv_start = (state_r == G_DOT) && !dot_le0 && ({1'b0, dotc} < len2_r);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      qx_r        <= '0;
      qy_r        <= '0;
      kind_r      <= ppht_pkg::KIND_NONE;
      vseen_r     <= '0;
      found_r     <= 1'b0;
      fid_r       <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            case (in_word.func)
              ppht_pkg::FUNC_START: begin
                qx_r    <= in_word.pos_x;
                qy_r    <= in_word.pos_y;
                found_r <= 1'b0;
                fid_r   <= '0;
                kind_r  <= ppht_pkg::KIND_NONE;
                vseen_r <= '0;
              end
              ppht_pkg::FUNC_HEADER: begin
                xf_r[0] <= in_word.pos_x;
                xf_r[1] <= in_word.pos_y;
                xf_r[2] <= in_word.axis1_x;
                xf_r[3] <= in_word.axis1_y;
                xf_r[4] <= in_word.axis2_x;
                xf_r[5] <= in_word.axis2_y;
                kind_r  <= (in_word.kind > ppht_pkg::KIND_CLOSED) ?
                           ppht_pkg::KIND_NONE : in_word.kind;
                rad_r   <= in_word.radius;
                wid_r   <= in_word.width;
                nid_r   <= in_word.node_id;
                vseen_r <= '0;
                state_r <= H_A1X;
              end
              ppht_pkg::FUNC_VERTEX: begin
                vx_r   <= in_word.pos_x;
                vy_r   <= in_word.pos_y;
                last_r <= in_word.last;
                // stray vertices are dropped
                if ((kind_r inside {ppht_pkg::KIND_LINE, ppht_pkg::KIND_OPEN,
                                    ppht_pkg::KIND_CLOSED}) && vseen_r != 2'd3)
                  state_r <= V_X1;
              end
              default: begin
                out_r.hit    <= found_r;
                out_r.hit_id <= found_r ? fid_r : '0;
                out_valid_r  <= 1'b1;
                state_r      <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        // axis lengths -> scale
        H_A1X: state_r <= H_A1Y;
        H_A1Y: begin acc_r <= prod_r; state_r <= H_S1; end
        H_S1:  state_r <= H_W1;
        H_W1: begin
          if (sq_done) begin
            l1_r    <= sq_root;
            state_r <= H_A2X;
          end
        end
        H_A2X: state_r <= H_A2Y;
        H_A2Y: begin acc_r <= prod_r; state_r <= H_S2; end
        H_S2:  state_r <= H_W2;
        H_W2: begin
          if (sq_done) begin
            scale_r <= mx[31] ? {31{1'b1}} : mx[30:0];
            state_r <= H_R;
          end
        end
        H_R: state_r <= H_W;
        H_W: begin
          srad_r  <= ppht_pkg::sat_u31(prod_r >>> FB);
          state_r <= H_D;
        end
        H_D: begin
          swid_r <= ppht_pkg::sat_u31(prod_r >>> FB);
          if (kind_r == ppht_pkg::KIND_DISC || kind_r == ppht_pkg::KIND_CIRCLE)
            state_r <= H_DY;
          else
            state_r <= S_IDLE;
        end
        H_DY: begin acc_r <= prod_r; state_r <= H_B; end
        H_B:  begin d2_r <= e_d2; state_r <= H_C; end
        H_C: begin
          // ring test needs the inner bound only when it is positive
          if (kind_r == ppht_pkg::KIND_CIRCLE && d2_r <= prod_r[64:0] &&
              srad_r > swid_r) begin
            state_r <= H_L;
          end else begin
            if (d2_r <= prod_r[64:0]) begin
              found_r <= 1'b1;
              fid_r   <= nid_r;
            end
            state_r <= S_IDLE;
          end
        end
        H_L: begin
          if (d2_r >= prod_r[64:0]) begin
            found_r <= 1'b1;
            fid_r   <= nid_r;
          end
          state_r <= S_IDLE;
        end
        // local vertex -> world
        V_X1: state_r <= V_X2;
        V_X2: begin acc_r <= ppht_pkg::ext_p(xf_r[0]) + psh; state_r <= V_Y1; end
        V_Y1: begin nwx_r <= ppht_pkg::sat32(acc_sh_sum); state_r <= V_Y2; end
        V_Y2: begin acc_r <= ppht_pkg::ext_p(xf_r[1]) + psh; state_r <= V_V; end
        V_V: begin
          pvx_r <= nwx_r;
          pvy_r <= nwy;
          if (vseen_r == 2'd0) begin
            fvx_r   <= nwx_r;
            fvy_r   <= nwy;
            vseen_r <= 2'd1;
            state_r <= V_LAST;
          end else begin
            sx_r    <= pvx_r;
            sy_r    <= pvy_r;
            ex_r    <= nwx_r;
            ey_r    <= nwy;
            close_r <= 1'b0;
            vseen_r <= 2'd2;
            state_r <= G_DX;
          end
        end
        V_LAST: begin
          if (last_r) begin
            vseen_r <= 2'd3;
            if (kind_r == ppht_pkg::KIND_CLOSED) begin
              sx_r    <= pvx_r;
              sy_r    <= pvy_r;
              ex_r    <= fvx_r;
              ey_r    <= fvy_r;
              close_r <= 1'b1;
              state_r <= G_DX;
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            state_r <= S_IDLE;
          end
        end
        // segment distance test
        G_DX: begin dx_r <= gdx; dy_r <= gdy; state_r <= G_DY; end
        G_DY: begin acc_r <= prod_r; state_r <= G_LIM; end
        G_LIM: begin len2_r <= e_d2; state_r <= G_T1; end
        G_T1: begin
          lim_r <= prod_r[64:0];
          if (len2_r == '0) begin
            cx_r    <= sx_r;
            cy_r    <= sy_r;
            state_r <= G_E1;
          end else begin
            state_r <= G_T2;
          end
        end
        G_T2: begin acc_r <= prod_r; state_r <= G_DOT; end
        G_DOT: begin
          if (dot_le0) begin
            cx_r    <= sx_r;
            cy_r    <= sy_r;
            state_r <= G_E1;
          end else if ({1'b0, dotc} >= len2_r) begin
            cx_r    <= ex_r;
            cy_r    <= ey_r;
            state_r <= G_E1;
          end else begin
            state_r <= G_DIV;
          end
        end
        G_DIV: begin
          if (dv_done) state_r <= G_CX;
        end
        G_CX: state_r <= G_CY;
        G_CY: begin
          cx_r    <= ppht_pkg::sat32(ppht_pkg::ext_p(sx_r) + psh);
          state_r <= G_CYW;
        end
        G_CYW: begin
          cy_r    <= ppht_pkg::sat32(ppht_pkg::ext_p(sy_r) + psh);
          state_r <= G_E1;
        end
        G_E1: state_r <= G_E2;
        G_E2: begin acc_r <= prod_r; state_r <= G_E3; end
        G_E3: begin
          if (e_d2 <= lim_r) begin
            found_r <= 1'b1;
            fid_r   <= nid_r;
          end
          state_r <= close_r ? S_IDLE : V_LAST;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* sim/tb_point_pick_hit_test.sv */
// Regression bench for point_pick_hit_test: directed and random picks checked
// against a cycle-free predictor of the hit test. Depends on ppht_pkg and the RTL.
`timescale 1ns / 100ps

module tb_point_pick_hit_test;

  localparam int  HALF_PERIOD = 10;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  ITEM_TARGET = 1800;
  localparam int  DRAIN_WAIT  = 200;     // > longest word (header or closing vertex)
  localparam int  HOLD_CYCLES = 400;     // long receiver hold-off
  localparam logic signed [31:0] ONE = 32'sh0001_0000;
  localparam int  FB = ppht_pkg::FRAC_BITS;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ppht_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ppht_pkg::out_word_t out_word;

  point_pick_hit_test u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always #HALF_PERIOD clk = ~clk;

  int                  errors = 0;
  int                  words_sent = 0;
  bit                  quiet = 1'b0;     // no idling on either side
  int                  hold_req = 0;     // bumped by the pressure test
  ppht_pkg::out_word_t pick_results[$];  // expected result words, oldest first

  // ---------------------------------------------------------------------
  // Predictor state: query point, current node, vertex tracking, hit.
  // ---------------------------------------------------------------------
  longint            qry_x, qry_y;
  longint            xf[6];            // tx, ty, a1x, a1y, a2x, a2y
  int                cur_kind;
  longint unsigned   rad_s, wid_s;
  logic [63:0]       cur_id;
  longint            first_v[2], prev_v[2];
  int                vtx_state;        // 0 none, 1 one, 2 several, 3 done
  bit                hit_flag;
  logic [63:0]       hit_ident;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned sum_sq(longint a, longint b);
    return longint'(a * a) + longint'(b * b);
  endfunction

  function automatic longint unsigned dist_sq(longint ax, longint ay, longint bx, longint by);
    return sum_sq(clamp32(ax - bx), clamp32(ay - by));
  endfunction

  // squared distance from query to segment against squared stroke width
  function automatic bit segment_hit(longint sx, longint sy, longint ex, longint ey);
    longint dx, dy, wx, wy, t1, t2, dot, cx, cy;
    longint unsigned len2, lim, rem, alpha;
    dx = clamp32(ex - sx);
    dy = clamp32(ey - sy);
    len2 = sum_sq(dx, dy);
    lim = wid_s * wid_s;
    if (len2 == 0) return dist_sq(qry_x, qry_y, sx, sy) <= lim;
    wx = clamp32(qry_x - sx);
    wy = clamp32(qry_y - sy);
    t1 = wx * dx;
    t2 = wy * dy;
    if (t1 > 0 && t2 > 64'sh7FFF_FFFF_FFFF_FFFF - t1) dot = 64'sh7FFF_FFFF_FFFF_FFFF;
    else dot = t1 + t2;
    if (dot <= 0) begin
      cx = sx; cy = sy;
    end else if (longint'(unsigned'(dot)) >= 0 && unsigned'(dot) >= len2) begin
      cx = ex; cy = ey;
    end else begin
      rem = unsigned'(dot);
      alpha = 0;
      for (int i = 0; i < FB; i++) begin
        rem <<= 1;
        alpha <<= 1;
        if (rem >= len2) begin
          rem -= len2;
          alpha |= 1;
        end
      end
      cx = clamp32(sx + ((longint'(alpha) * dx) >>> FB));
      cy = clamp32(sy + ((longint'(alpha) * dy) >>> FB));
    end
    return dist_sq(qry_x, qry_y, cx, cy) <= lim;
  endfunction

  task automatic clear_pick_state();
    qry_x = 0; qry_y = 0;
    foreach (xf[i]) xf[i] = 0;
    cur_kind = ppht_pkg::KIND_NONE;
    rad_s = 0; wid_s = 0; cur_id = 0;
    first_v = '{0, 0}; prev_v = '{0, 0};
    vtx_state = 0; hit_flag = 0; hit_ident = 0;
  endtask

  task automatic mark_hit();
    hit_flag = 1;
    hit_ident = cur_id;
  endtask

  task automatic predict_word(input ppht_pkg::in_word_t w);
    longint px, py, wx, wy;
    longint unsigned l1, l2, scale, v, d2, hi, lo;
    bit inside_ring;
    ppht_pkg::out_word_t res;
    px = longint'(w.pos_x);
    py = longint'(w.pos_y);
    case (w.func)
      ppht_pkg::FUNC_START: begin
        qry_x = px; qry_y = py;
        hit_flag = 0; hit_ident = 0;
        cur_kind = ppht_pkg::KIND_NONE; vtx_state = 0;
      end
      ppht_pkg::FUNC_HEADER: begin
        xf[0] = px; xf[1] = py;
        xf[2] = longint'(w.axis1_x); xf[3] = longint'(w.axis1_y);
        xf[4] = longint'(w.axis2_x); xf[5] = longint'(w.axis2_y);
        cur_kind = (w.kind > ppht_pkg::KIND_CLOSED) ? int'(ppht_pkg::KIND_NONE) :
                   int'(w.kind);
        cur_id = w.node_id;
        vtx_state = 0;
        l1 = floor_sqrt(sum_sq(xf[2], xf[3]));
        l2 = floor_sqrt(sum_sq(xf[4], xf[5]));
        scale = (l1 > l2) ? l1 : l2;
        if (scale > 64'h7FFF_FFFF) scale = 64'h7FFF_FFFF;
        v = (longint'(w.radius) * scale) >> FB;
        rad_s = (v > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : v;
        v = (longint'(w.width) * scale) >> FB;
        wid_s = (v > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : v;
        if (cur_kind == ppht_pkg::KIND_DISC || cur_kind == ppht_pkg::KIND_CIRCLE) begin
          d2 = dist_sq(qry_x, qry_y, xf[0], xf[1]);
          if (cur_kind == ppht_pkg::KIND_DISC) begin
            inside_ring = d2 <= rad_s * rad_s;
          end else begin
            hi = rad_s + wid_s;
            inside_ring = d2 <= hi * hi;
            if (inside_ring && rad_s > wid_s) begin
              lo = rad_s - wid_s;
              inside_ring = d2 >= lo * lo;
            end
          end
          if (inside_ring) mark_hit();
        end
      end
      ppht_pkg::FUNC_VERTEX: begin
        if (cur_kind >= ppht_pkg::KIND_LINE && cur_kind <= ppht_pkg::KIND_CLOSED &&
            vtx_state != 3) begin
          wx = clamp32(xf[0] + ((xf[2] * px) >>> FB) + ((xf[4] * py) >>> FB));
          wy = clamp32(xf[1] + ((xf[3] * px) >>> FB) + ((xf[5] * py) >>> FB));
          if (vtx_state == 0) begin
            first_v = '{wx, wy};
            vtx_state = 1;
          end else begin
            if (segment_hit(prev_v[0], prev_v[1], wx, wy)) mark_hit();
            vtx_state = 2;
          end
          prev_v = '{wx, wy};
          if (w.last) begin
            // closing segment, also for a lone vertex
            if (cur_kind == ppht_pkg::KIND_CLOSED &&
                segment_hit(prev_v[0], prev_v[1], first_v[0], first_v[1]))
              mark_hit();
            vtx_state = 3;
          end
        end
      end
      default: begin
        res.hit    = hit_flag;
        res.hit_id = hit_flag ? hit_ident : 64'd0;
        pick_results.insert(pick_results.size(), res);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Word builders
  // ---------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic ppht_pkg::in_word_t noise_word();
    logic [351:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(ppht_pkg::in_word_t)-1:0];
  endfunction

  function automatic ppht_pkg::in_word_t pt_word(logic [1:0] f, logic signed [31:0] x,
                                                 logic signed [31:0] y, int lst);
    ppht_pkg::in_word_t w;
    w = noise_word();   // unused fields carry junk
    w.func = f; w.pos_x = x; w.pos_y = y; w.last = lst[0];
    return w;
  endfunction

  function automatic ppht_pkg::in_word_t hdr_word(logic [2:0] k, logic signed [31:0] tx,
      logic signed [31:0] ty, logic signed [31:0] a1x, logic signed [31:0] a1y,
      logic signed [31:0] a2x, logic signed [31:0] a2y, logic [31:0] r,
      logic [31:0] wd, logic [63:0] id);
    ppht_pkg::in_word_t w;
    w = noise_word();
    w.func = ppht_pkg::FUNC_HEADER; w.kind = k; w.pos_x = tx; w.pos_y = ty;
    w.axis1_x = a1x; w.axis1_y = a1y; w.axis2_x = a2x; w.axis2_y = a2y;
    w.radius = r[30:0]; w.width = wd[30:0]; w.node_id = id;
    return w;
  endfunction

  function automatic ppht_pkg::in_word_t unit_hdr(logic [2:0] k, logic signed [31:0] tx,
      logic signed [31:0] ty, logic [31:0] r, logic [31:0] wd, logic [63:0] id);
    return hdr_word(k, tx, ty, ONE, 0, 0, ONE, r, wd, id);
  endfunction

  function automatic logic signed [31:0] jitter(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: one word per call, random gaps before it, predict on accept.
  // ---------------------------------------------------------------------
  task automatic send_word(input ppht_pkg::in_word_t w);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    predict_word(w);
    words_sent++;
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // block has no pending work once results drained and a header's worth passed
  task automatic drain();
    go_idle();
    wait (pick_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request.
  // ---------------------------------------------------------------------
  int hold_seen = 0;
  int hold_left = 0;
  int burst_left = 0;

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left <= burst_left - 1;
      out_stall  <= 1'b1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      burst_left <= $urandom_range(0, 2);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // result checker: every accepted word against the oldest expectation
  always @(posedge clk) begin
    ppht_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pick_results.size() == 0) begin
        report("unexpected result word", out_word.hit_id, 64'd0);
      end else begin
        want = pick_results.pop_front();
        if (out_word.hit !== want.hit)
          report("hit", 64'(out_word.hit), 64'(want.hit));
        if (out_word.hit_id !== want.hit_id)
          report("hit_id", out_word.hit_id, want.hit_id);
      end
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("point_pick_hit_test regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------
  // finish straight after reset: nothing found
  task automatic test_empty_pick();
    send_word(pt_word(ppht_pkg::FUNC_FINISH, 0, 0, 0));
  endtask

  // discs and rings; later hit overrides; boundary at exact radius
  task automatic test_discs_circles();
    send_word(pt_word(ppht_pkg::FUNC_START, 0, 0, 0));
    send_word(unit_hdr(ppht_pkg::KIND_DISC, 2 * ONE, 0, 2 * ONE, 0, 64'h11));   // edge
    send_word(unit_hdr(ppht_pkg::KIND_CIRCLE, 0, 0, 3 * ONE, ONE, 64'h22));     // in hole
    send_word(unit_hdr(ppht_pkg::KIND_CIRCLE, ONE, 0, ONE, ONE / 4, 64'h33));   // on ring
    send_word(pt_word(ppht_pkg::FUNC_FINISH, 0, 0, 0));
  endtask

  // line, lone open vertex, lone closed vertex, triangle closing edge, strays
  task automatic test_polylines();
    send_word(pt_word(ppht_pkg::FUNC_START, ONE, ONE, 0));
    send_word(unit_hdr(ppht_pkg::KIND_LINE, 0, 0, 0, ONE / 8, 64'h44));
    send_word(pt_word(ppht_pkg::FUNC_VERTEX, 0, 0, 0));
    send_word(pt_word(ppht_pkg::FUNC_VERTEX, 2 * ONE, 2 * ONE, 1));
    send_word(pt_word(ppht_pkg::FUNC_VERTEX, ONE, ONE, 1));            // after last
    send_word(unit_hdr(ppht_pkg::KIND_OPEN, ONE, ONE, 0, ONE, 64'h55));
    send_word(pt_word(ppht_pkg::FUNC_VERTEX, 0, 0, 1));                // lone, no hit
    send_word(unit_hdr(ppht_pkg::KIND_CLOSED, 0, 0, 0, ONE / 16, 64'h66));
    send_word(pt_word(ppht_pkg::FUNC_VERTEX, ONE, ONE, 1));            // lone closed
    send_word(unit_hdr(ppht_pkg::KIND_CLOSED, 0, 0, 0, ONE / 16, 64'h77));
    send_word(pt_word(ppht_pkg::FUNC_VERTEX, 2 * ONE, 0, 0));
    send_word(pt_word(ppht_pkg::FUNC_VERTEX, 2 * ONE, 2 * ONE, 0));
    send_word(pt_word(ppht_pkg::FUNC_VERTEX, 0, 0, 1));                // diagonal edge hits
    send_word(unit_hdr(ppht_pkg::KIND_DISC, 0, 0, ONE, 0, 64'h88));
    send_word(pt_word(ppht_pkg::FUNC_VERTEX, ONE, ONE, 1));            // stray on disc
    send_word(pt_word(ppht_pkg::FUNC_FINISH, 0, 0, 0));
  endtask

  // saturating extremes and an out-of-range kind
  task automatic test_extremes();
    send_word(pt_word(ppht_pkg::FUNC_START, 32'sh7FFF_FFFF, 32'sh8000_0000, 0));
    send_word(hdr_word(3'd7, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                       32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_word(hdr_word(ppht_pkg::KIND_CIRCLE, 32'sh8000_0000, 32'sh7FFF_FFFF,
                       32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE));
    send_word(hdr_word(ppht_pkg::KIND_CLOSED, 32'sh7FFF_FFFF, 32'sh8000_0000,
                       32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                       0, 32'h7FFF_FFFF, 64'h1));
    send_word(pt_word(ppht_pkg::FUNC_VERTEX, 32'sh8000_0000, 32'sh7FFF_FFFF, 0));
    send_word(pt_word(ppht_pkg::FUNC_VERTEX, 32'sh7FFF_FFFF, 32'sh8000_0000, 1));
    send_word(pt_word(ppht_pkg::FUNC_FINISH, 0, 0, 0));
  endtask

  // ---------------------------------------------------------------------
  // Random picks: mostly well-formed around the query, some raw noise.
  // ---------------------------------------------------------------------
  task automatic send_random_pick(input int max_nodes);
    logic signed [31:0] qx, qy, a;
    logic [2:0] k;
    int nv;
    qx = jitter(8 * ONE);
    qy = jitter(8 * ONE);
    send_word(pt_word(ppht_pkg::FUNC_START, qx, qy, 0));
    repeat ($urandom_range(0, max_nodes)) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(noise_word());
        continue;
      end
      k = 3'($urandom_range(0, 7));
      a = 2 * ONE;
      send_word(hdr_word(k, qx + jitter(3 * ONE), qy + jitter(3 * ONE),
                         jitter(a), jitter(a), jitter(a), jitter(a),
                         $urandom_range(0, 3 * ONE), $urandom_range(0, ONE / 2),
                         rand64()));
      nv = (k >= ppht_pkg::KIND_LINE && k <= ppht_pkg::KIND_CLOSED) ?
           $urandom_range(1, 4) : $urandom_range(0, 1);
      for (int i = 0; i < nv; i++)
        send_word(pt_word(ppht_pkg::FUNC_VERTEX, jitter(2 * ONE), jitter(2 * ONE),
                          (i == nv - 1) ? int'($urandom_range(0, 5) != 0) : 0));
    end
    send_word(pt_word(ppht_pkg::FUNC_FINISH, 0, 0, 0));
  endtask

  task automatic test_random_picks();
    while (words_sent < ITEM_TARGET) begin
      if (words_sent > ITEM_TARGET * 85 / 100) quiet = 1'b1;
      send_random_pick(4);
    end
  endtask

  // receiver holds off long while picks keep coming; input backs up
  task automatic test_backpressure();
    hold_req++;
    repeat (4) begin
      send_word(pt_word(ppht_pkg::FUNC_START, 0, 0, 0));
      send_word(unit_hdr(ppht_pkg::KIND_DISC, 0, 0, ONE, 0, rand64()));
      send_word(pt_word(ppht_pkg::FUNC_FINISH, 0, 0, 0));
    end
  endtask

  initial begin
    clear_pick_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_pick();
    test_discs_circles();
    test_polylines();
    test_extremes();
    test_backpressure();
    test_random_picks();

    drain();
    if (errors == 0) begin
      $display("point_pick_hit_test regression: pass");
    end else begin
      $display("point_pick_hit_test regression: fail");
    end
    $finish;
  end

endmodule
